/* hw/rtl/rrw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrw_pkg
// Shared constants, codes and types of the rotor router walk block.
// ----------------------------------------------------------------------------
package rrw_pkg;

  // graph and counter sizes
  localparam int unsigned MAX_VERTICES = 16;
  localparam int unsigned MAX_DEGREE   = 8;
  localparam int unsigned MAX_EDGE_IDS = 64;
  localparam int unsigned COUNT_WIDTH  = 32;

  // field widths
  localparam int unsigned OP_W     = 3;
  localparam int unsigned VTX_W    = 4;
  localparam int unsigned SLOT_W   = 3;
  localparam int unsigned EID_W    = 6;
  localparam int unsigned DEG_W    = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned VCOUNT_W = 5;

  // slot table: neighbor and edge id packed per entry, addressed by {vertex, slot}
  localparam int unsigned TBL_DEPTH = MAX_VERTICES * MAX_DEGREE;
  localparam int unsigned TBL_W     = VTX_W + EID_W;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = VCOUNT_W'(16);
  localparam logic [VCOUNT_W-1:0] VCOUNT_LIMIT = VCOUNT_W'(MAX_VERTICES);

  // operation codes
  localparam logic [OP_W-1:0] OP_LOAD  = 3'd0;
  localparam logic [OP_W-1:0] OP_SET   = 3'd1;
  localparam logic [OP_W-1:0] OP_START = 3'd2;
  localparam logic [OP_W-1:0] OP_STEP  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ  = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_EDGE = 2'd2;

  // input item
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [VTX_W-1:0]  vertex;
    logic [SLOT_W-1:0] slot;
    logic [VTX_W-1:0]  neighbor;
    logic [EID_W-1:0]  edge_id;
    logic [DEG_W-1:0]  degree;
  } rrw_item_t;

  // result item
  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [VTX_W-1:0]       from_vertex;
    logic [VTX_W-1:0]       to_vertex;
    logic [EID_W-1:0]       crossed_edge;
    logic [SLOT_W-1:0]      slot_used;
    logic [COUNT_WIDTH-1:0] vertex_visits;
    logic [COUNT_WIDTH-1:0] edge_visits;
  } rrw_result_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
    logic tbl;
    logic cnt;
    logic emit;
  } rrw_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic go_step;
    logic go_read;
  } rrw_sts_t;

endpackage

/* hw/rtl/rrw_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrw_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rrw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/rrw_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrw_ctrl
// Sequencer: accepts an item, runs execute and, as needed, the table read and
// counter update phases, and tells the datapath when to deliver the result.
// ----------------------------------------------------------------------------
module rrw_ctrl
  import rrw_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  rrw_sts_t sts_i,
  output rrw_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_TBL  = 2'd2;
  localparam logic [1:0] S_CNT  = 2'd3;

  logic [1:0] state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (sts_i.go_step) begin
          state_d = S_TBL;
        end else if (sts_i.go_read) begin
          state_d = S_CNT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_TBL: begin
        state_d = S_CNT;
      end
      S_CNT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // commands
  assign busy          = (state_q != S_IDLE);
  assign cmd_o.capture = (state_q == S_IDLE) && start;
  assign cmd_o.exec    = (state_q == S_EXEC);
  assign cmd_o.tbl     = (state_q == S_TBL);
  assign cmd_o.cnt     = (state_q == S_CNT);
  assign cmd_o.emit    = ((state_q == S_EXEC) && !sts_i.go_step && !sts_i.go_read)
                         || (state_q == S_CNT);

  // checks
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> state_q == S_EXEC)
    else $error("accepted item did not enter execute");

  a_tbl_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TBL |=> state_q == S_CNT)
    else $error("table read not followed by counter update");

  a_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> state_q == S_IDLE)
    else $error("result delivered but sequencer still busy");

endmodule

/* hw/rtl/rrw_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrw_datapath
// Graph tables, rotors, agent position and saturating visit counters, with
// argument checks and the result register.
// ----------------------------------------------------------------------------
module rrw_datapath
  import rrw_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [VCOUNT_W-1:0] cfg_wdata_i,
  input  rrw_item_t           item_i,
  input  rrw_cmd_t            cmd_i,
  output rrw_sts_t            sts_o,
  output rrw_result_t         result_o,
  output logic                done_o
);

  localparam int unsigned TBL_AW = $clog2(TBL_DEPTH);
  localparam int unsigned VV_AW  = $clog2(MAX_VERTICES);
  localparam int unsigned EV_AW  = $clog2(MAX_EDGE_IDS);

  logic [VCOUNT_W-1:0]    vcount_q;
  rrw_item_t              item_q;
  logic [VTX_W-1:0]       cur_q;
  logic [DEG_W-1:0]       degree_q [MAX_VERTICES];
  logic [SLOT_W-1:0]      rotor_q [MAX_VERTICES];
  logic [VTX_W-1:0]       from_q, to_q;
  logic [EID_W-1:0]       e_q;
  logic [SLOT_W-1:0]      r_q;
  logic [MAX_VERTICES-1:0] vv_valid_q;
  logic [MAX_EDGE_IDS-1:0] ev_valid_q;
  rrw_result_t            result_q, result_d;
  logic                   done_q;

  logic [VCOUNT_W-1:0]    lim;
  logic                   v_bad, nb_bad, cur_bad, slot_bad, eid_bad, deg_bad, rot_bad;
  logic [DEG_W-1:0]       cur_deg;
  logic [SLOT_W-1:0]      cur_rot, rot_use;
  logic [STATUS_W-1:0]    status_d;
  logic                   ok, is_step;

  logic                   tbl_we;
  logic [TBL_AW-1:0]      tbl_waddr, tbl_raddr;
  logic [TBL_W-1:0]       tbl_wdata, tbl_rdata;
  logic [VTX_W-1:0]       tbl_to;
  logic [EID_W-1:0]       tbl_e;

  logic [VV_AW-1:0]       vv_raddr;
  logic [EV_AW-1:0]       ev_raddr;
  logic [COUNT_WIDTH-1:0] vv_rdata, ev_rdata;
  logic [COUNT_WIDTH-1:0] vv_cur, ev_cur, vv_inc, ev_inc;
  logic                   cnt_we;

  logic [DEG_W-1:0]       from_deg, r_plus;
  logic [SLOT_W-1:0]      rot_next;

  // argument checks against the vertices in use and the table sizes
  assign lim      = (vcount_q > VCOUNT_LIMIT) ? VCOUNT_LIMIT : vcount_q;
  assign v_bad    = VCOUNT_W'(item_q.vertex) >= lim;
  assign nb_bad   = VCOUNT_W'(item_q.neighbor) >= lim;
  assign cur_bad  = VCOUNT_W'(cur_q) >= lim;
  assign slot_bad = 32'(item_q.slot) >= MAX_DEGREE;
  assign eid_bad  = 32'(item_q.edge_id) >= MAX_EDGE_IDS;
  assign deg_bad  = 32'(item_q.degree) > MAX_DEGREE;
  assign rot_bad  = (item_q.degree != '0) && (DEG_W'(item_q.slot) >= item_q.degree);

  // rotor of the current vertex, wrapped if out of range
  assign cur_deg = degree_q[cur_q];
  assign cur_rot = rotor_q[cur_q];
  assign rot_use = (DEG_W'(cur_rot) >= cur_deg) ? '0 : cur_rot;

  // status decode
  always_comb begin
    status_d = STATUS_OK;
    unique case (item_q.op)
      OP_LOAD: begin
        if (v_bad || nb_bad || slot_bad || eid_bad) status_d = STATUS_BAD;
      end
      OP_SET: begin
        if (v_bad || deg_bad || rot_bad) status_d = STATUS_BAD;
      end
      OP_START: begin
        if (v_bad) status_d = STATUS_BAD;
      end
      OP_STEP: begin
        if (cur_bad) begin
          status_d = STATUS_BAD;
        end else if (cur_deg == '0) begin
          status_d = STATUS_NO_EDGE;
        end
      end
      OP_READ: begin
        if (v_bad || eid_bad) status_d = STATUS_BAD;
      end
      default: begin
        status_d = STATUS_BAD;
      end
    endcase
  end

  assign ok            = (status_d == STATUS_OK);
  assign is_step       = (item_q.op == OP_STEP);
  assign sts_o.go_step = is_step && ok;
  assign sts_o.go_read = (item_q.op == OP_READ) && ok;

  // slot table
  assign tbl_we    = cmd_i.exec && (item_q.op == OP_LOAD) && ok;
  assign tbl_waddr = {item_q.vertex, item_q.slot};
  assign tbl_wdata = {item_q.neighbor, item_q.edge_id};
  assign tbl_raddr = {cur_q, rot_use};
  assign tbl_to    = tbl_rdata[TBL_W-1 -: VTX_W];
  assign tbl_e     = tbl_rdata[EID_W-1:0];

  rrw_ram #(
    .WIDTH(TBL_W),
    .DEPTH(TBL_DEPTH)
  ) u_tbl_ram (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(tbl_waddr),
    .wdata_i(tbl_wdata),
    .raddr_i(tbl_raddr),
    .rdata_o(tbl_rdata)
  );

  // counter reads: item arguments for a read, crossing for a step
  assign vv_raddr = cmd_i.exec ? item_q.vertex : tbl_to;
  assign ev_raddr = cmd_i.exec ? item_q.edge_id : tbl_e;

  // entries not written since the last start read as zero
  assign vv_cur = vv_valid_q[to_q] ? vv_rdata : '0;
  assign ev_cur = ev_valid_q[e_q] ? ev_rdata : '0;
  assign vv_inc = (&vv_cur) ? vv_cur : vv_cur + COUNT_WIDTH'(1);
  assign ev_inc = (&ev_cur) ? ev_cur : ev_cur + COUNT_WIDTH'(1);
  assign cnt_we = cmd_i.cnt && is_step;

  rrw_ram #(
    .WIDTH(COUNT_WIDTH),
    .DEPTH(MAX_VERTICES)
  ) u_vv_ram (
    .clk_i  (clk_i),
    .we_i   (cnt_we),
    .waddr_i(to_q),
    .wdata_i(vv_inc),
    .raddr_i(vv_raddr),
    .rdata_o(vv_rdata)
  );

  rrw_ram #(
    .WIDTH(COUNT_WIDTH),
    .DEPTH(MAX_EDGE_IDS)
  ) u_ev_ram (
    .clk_i  (clk_i),
    .we_i   (cnt_we),
    .waddr_i(e_q),
    .wdata_i(ev_inc),
    .raddr_i(ev_raddr),
    .rdata_o(ev_rdata)
  );

  // rotor advance with wrap at degree
  assign from_deg = degree_q[from_q];
  assign r_plus   = DEG_W'(r_q) + DEG_W'(1);
  assign rot_next = (r_plus >= from_deg) ? '0 : r_plus[SLOT_W-1:0];

  // result assembly
  always_comb begin
    result_d = '0;
    if (cmd_i.cnt) begin
      result_d.status = STATUS_OK;
      if (is_step) begin
        result_d.from_vertex   = from_q;
        result_d.to_vertex     = to_q;
        result_d.crossed_edge  = e_q;
        result_d.slot_used     = r_q;
        result_d.vertex_visits = vv_inc;
        result_d.edge_visits   = ev_inc;
      end else begin
        result_d.vertex_visits = vv_cur;
        result_d.edge_visits   = ev_cur;
      end
    end else begin
      result_d.status = status_d;
    end
  end

  // item capture and crossing registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= item_i;
    end
    if (cmd_i.exec) begin
      from_q <= cur_q;
      r_q    <= rot_use;
      to_q   <= item_q.vertex;
      e_q    <= item_q.edge_id;
    end else if (cmd_i.tbl) begin
      to_q <= tbl_to;
      e_q  <= tbl_e;
    end
    if (cmd_i.emit) begin
      result_q <= result_d;
    end
  end

  // configuration, walk state and counter valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q   <= VCOUNT_RESET;
      cur_q      <= '0;
      vv_valid_q <= '0;
      ev_valid_q <= '0;
      done_q     <= 1'b0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
        degree_q[i] <= '0;
        rotor_q[i]  <= '0;
      end
    end else begin
      done_q <= cmd_i.emit;
      if (cfg_we_i) begin
        vcount_q <= cfg_wdata_i;
      end
      if (cmd_i.exec && ok && (item_q.op == OP_SET)) begin
        degree_q[item_q.vertex] <= item_q.degree;
        rotor_q[item_q.vertex]  <= (item_q.degree == '0) ? '0 : item_q.slot;
      end
      if (cmd_i.exec && ok && (item_q.op == OP_START)) begin
        cur_q      <= item_q.vertex;
        vv_valid_q <= '0;
        ev_valid_q <= '0;
      end
      if (cnt_we) begin
        rotor_q[from_q]  <= rot_next;
        cur_q            <= to_q;
        vv_valid_q[to_q] <= 1'b1;
        ev_valid_q[e_q]  <= 1'b1;
      end
    end
  end

  assign result_o = result_q;
  assign done_o   = done_q;

  // checks
  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && (result_q.status != STATUS_OK) |->
      (result_q.vertex_visits == '0) && (result_q.edge_visits == '0)
      && (result_q.from_vertex == '0) && (result_q.to_vertex == '0))
    else $error("rejected item carries nonzero fields");

  a_step_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_we |=> cur_q == $past(to_q))
    else $error("agent did not move to the crossed neighbor");

endmodule

/* hw/rtl/rotor_router_walk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotor_router_walk
// Rotor router walk of one agent over a loaded graph of up to 16 vertices.
// ----------------------------------------------------------------------------
// One item at a time: busy rises the cycle after an item is taken and falls
// when its result is produced; done_o then marks result_o for one cycle and
// the result must be taken in that cycle. Load, set, start and rejected items
// end in the execute state, a read adds the counter update state (one counter
// memory read), and a step adds a table read state first: the current vertex's
// rotor picks a slot table entry, that read gives the neighbor and edge, and the
// counter memories are read and written back. No clearing pass is needed after
// reset; a start clears the counters at once through per-entry valid bits.
module rotor_router_walk
  import rrw_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  rrw_item_t           item_i,
  output rrw_result_t         result_o,
  output logic                done_o,
  input  logic                cfg_we_i,
  input  logic [VCOUNT_W-1:0] cfg_wdata_i
);

  rrw_cmd_t cmd;
  rrw_sts_t sts;

  // sequencer
  rrw_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .sts_i (sts),
    .cmd_o (cmd)
  );

  // tables, counters and result register
  rrw_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .item_i     (item_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .result_o   (result_o),
    .done_o     (done_o)
  );

endmodule
